[hw/rtl/bsct_pkg.sv]
// shared types and constants for the box and sphere contact test
package bsct_pkg;

    localparam int SQRT_STAGES = 31;
    localparam int DIV_STAGES  = 14;
    localparam int RAD_W       = 62;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic             sphere;
        logic             hit;
        logic [31:0]      depth;
        logic [2:0][15:0] nrm;
        logic [2:0][31:0] pnt;
        logic [2:0][30:0] ad;
        logic [2:0]       neg;
        logic [30:0]      rs;
    } item_t;

endpackage

[hw/rtl/bsct_front.sv]
// front stages: differences, box test, squares and sphere compare
module bsct_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         sphere,
    input  logic [2:0][31:0]             pa,
    input  logic [2:0][31:0]             pb,
    input  logic [2:0][30:0]             ext,
    output logic                         out_valid,
    output bsct_pkg::item_t              out_item,
    output logic [bsct_pkg::RAD_W-1:0]   out_rad
);

    logic             va_reg;
    logic             sph_a_reg;
    logic [2:0][31:0] ad_a_reg;
    logic [2:0]       neg_a_reg;
    logic [2:0][30:0] ext_a_reg;
    logic [2:0][31:0] pnt_a_reg;

    logic [2:0][31:0] ad_a_next;
    logic [2:0]       neg_a_next;
    logic [2:0][31:0] pnt_a_next;

    logic             vb_reg;
    bsct_pkg::item_t  item_b_reg;
    logic [2:0][61:0] sq_b_reg;
    logic [61:0]      rs2_b_reg;

    bsct_pkg::item_t  item_b_next;
    logic [2:0][61:0] sq_b_next;
    logic [61:0]      rs2_b_next;

    logic             vc_reg;
    bsct_pkg::item_t  item_c_reg;
    logic [61:0]      rad_c_reg;

    bsct_pkg::item_t  item_c_next;
    logic [63:0]      d2;

    logic [32:0]      diff;
    logic [32:0]      adw;
    logic [32:0]      sum;
    logic             box_hit;
    logic             pre_hit;
    logic [2:0][30:0] pen;
    logic [30:0]      best;
    logic [1:0]       axis;

    // differences and midpoints
    always_comb
    begin
        ad_a_next  = '0;
        neg_a_next = '0;
        pnt_a_next = '0;
        diff = '0;
        adw  = '0;
        sum  = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
            adw  = diff[32] ? (33'd0 - diff) : diff;
            sum  = {pa[i][31], pa[i]} + {pb[i][31], pb[i]};
            neg_a_next[i] = diff[32];
            ad_a_next[i]  = adw[31:0];
            pnt_a_next[i] = sum[32:1];
        end
    end

    // box selection and squares
    always_comb
    begin
        box_hit = 1'b1;
        pre_hit = 1'b1;
        pen  = '0;
        best = '0;
        axis = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (ad_a_reg[i] > {1'b0, ext_a_reg[i]})
                box_hit = 1'b0;
            if (ad_a_reg[i] > {1'b0, ext_a_reg[0]})
                pre_hit = 1'b0;
            pen[i] = ext_a_reg[i] - ad_a_reg[i][30:0];
        end
        best = pen[0];
        if (pen[1] < best)
        begin
            best = pen[1];
            axis = 2'd1;
        end
        if (pen[2] < best)
        begin
            best = pen[2];
            axis = 2'd2;
        end

        item_b_next.sphere = sph_a_reg;
        item_b_next.hit    = sph_a_reg ? pre_hit : box_hit;
        item_b_next.depth  = {1'b0, best};
        item_b_next.pnt    = pnt_a_reg;
        item_b_next.neg    = neg_a_reg;
        item_b_next.rs     = ext_a_reg[0];
        item_b_next.nrm    = '0;
        for (int i = 0; i < 3; i++)
        begin
            item_b_next.ad[i] = ad_a_reg[i][30:0];
            sq_b_next[i] = 62'(ad_a_reg[i][30:0]) * 62'(ad_a_reg[i][30:0]);
        end
        item_b_next.nrm[axis] = neg_a_reg[axis] ? -bsct_pkg::ONE_Q14 : bsct_pkg::ONE_Q14;
        rs2_b_next = 62'(ext_a_reg[0]) * 62'(ext_a_reg[0]);
    end

    // squared distance against squared radius sum
    always_comb
    begin
        d2 = 64'(sq_b_reg[0]) + 64'(sq_b_reg[1]) + 64'(sq_b_reg[2]);
        item_c_next = item_b_reg;
        if (item_b_reg.sphere && (d2 >= {2'b00, rs2_b_reg}))
            item_c_next.hit = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sph_a_reg  <= sphere;
        ad_a_reg   <= ad_a_next;
        neg_a_reg  <= neg_a_next;
        ext_a_reg  <= ext;
        pnt_a_reg  <= pnt_a_next;
        item_b_reg <= item_b_next;
        sq_b_reg   <= sq_b_next;
        rs2_b_reg  <= rs2_b_next;
        item_c_reg <= item_c_next;
        rad_c_reg  <= d2[61:0];
    end

    assign out_valid = vc_reg;
    assign out_item  = item_c_reg;
    assign out_rad   = rad_c_reg;

endmodule

[hw/rtl/bsct_sqrt.sv]
// pipelined integer square root, one result bit per stage
module bsct_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  bsct_pkg::item_t              in_item,
    input  logic [bsct_pkg::RAD_W-1:0]   in_rad,
    output logic                         out_valid,
    output bsct_pkg::item_t              out_item,
    output logic [30:0]                  out_root
);

    localparam int NS = bsct_pkg::SQRT_STAGES;

    logic                         valid_reg [NS];
    bsct_pkg::item_t              item_reg  [NS];
    logic [bsct_pkg::RAD_W-1:0]   rad_reg   [NS];
    logic [32:0]                  rem_reg   [NS];
    logic [30:0]                  root_reg  [NS];

    logic [bsct_pkg::RAD_W-1:0]   rad_next  [NS];
    logic [32:0]                  rem_next  [NS];
    logic [30:0]                  root_next [NS];

    logic [bsct_pkg::RAD_W-1:0]   rad_cur;
    logic [32:0]                  rem_cur;
    logic [30:0]                  root_cur;
    logic [34:0]                  rem_sh;
    logic [34:0]                  trial;

    always_comb
    begin
        rad_cur  = '0;
        rem_cur  = '0;
        root_cur = '0;
        rem_sh   = '0;
        trial    = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                rad_cur  = in_rad;
                rem_cur  = '0;
                root_cur = '0;
            end
            else
            begin
                rad_cur  = rad_reg[s-1];
                rem_cur  = rem_reg[s-1];
                root_cur = root_reg[s-1];
            end
            rem_sh = {rem_cur, rad_cur[bsct_pkg::RAD_W-1 -: 2]};
            trial  = {2'b00, root_cur, 2'b01};
            rad_next[s] = {rad_cur[bsct_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[s]  = 33'(rem_sh - trial);
                root_next[s] = {root_cur[29:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_sh[32:0];
                root_next[s] = {root_cur[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[0] <= in_item;
        for (int s = 1; s < NS; s++)
            item_reg[s] <= item_reg[s-1];
        for (int s = 0; s < NS; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_item  = item_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule

[hw/rtl/bsct_div.sv]
// pipelined normal division and result formatting
module bsct_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bsct_pkg::item_t     in_item,
    input  logic [30:0]         in_root,
    output logic                out_valid,
    output logic                out_hit,
    output logic [31:0]         out_depth,
    output logic [2:0][15:0]    out_nrm,
    output logic [2:0][31:0]    out_pnt
);

    localparam int ND = bsct_pkg::DIV_STAGES;

    logic               v0_reg;
    bsct_pkg::item_t    item0_reg;
    logic [31:0]        dist0_reg;
    logic [31:0]        sdepth0_reg;
    logic [31:0]        dist0_next;

    logic               valid_reg [ND];
    bsct_pkg::item_t    item_reg  [ND];
    logic [31:0]        dist_reg  [ND];
    logic [31:0]        sdep_reg  [ND];
    logic [2:0][31:0]   rem_reg   [ND];
    logic [2:0][13:0]   q_reg     [ND];

    logic [2:0][31:0]   rem_next  [ND];
    logic [2:0][13:0]   q_next    [ND];

    logic [2:0][31:0]   rem_cur;
    logic [2:0][13:0]   q_cur;
    logic [31:0]        dist_cur;
    logic [31:0]        rem_sh;

    logic               v_out_reg;
    logic               hit_reg;
    logic [31:0]        depth_reg;
    logic [2:0][15:0]   nrm_reg;
    logic [2:0][31:0]   pnt_reg;

    logic               hit_next;
    logic [31:0]        depth_next;
    logic [2:0][15:0]   nrm_next;
    logic [2:0][31:0]   pnt_next;

    bsct_pkg::item_t    last_item;
    logic [15:0]        qe;

    assign dist0_next = {1'b0, in_root} + 32'd1;

    always_comb
    begin
        rem_cur  = '0;
        q_cur    = '0;
        dist_cur = '0;
        rem_sh   = '0;
        for (int s = 0; s < ND; s++)
        begin
            if (s == 0)
            begin
                dist_cur = dist0_reg;
                q_cur    = '0;
                for (int i = 0; i < 3; i++)
                    rem_cur[i] = {1'b0, item0_reg.ad[i]};
            end
            else
            begin
                dist_cur = dist_reg[s-1];
                q_cur    = q_reg[s-1];
                rem_cur  = rem_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                rem_sh = {rem_cur[i][30:0], 1'b0};
                if (rem_sh >= dist_cur)
                begin
                    rem_next[s][i] = rem_sh - dist_cur;
                    q_next[s][i]   = {q_cur[i][12:0], 1'b1};
                end
                else
                begin
                    rem_next[s][i] = rem_sh;
                    q_next[s][i]   = {q_cur[i][12:0], 1'b0};
                end
            end
        end
    end

    // final result, zeros on a miss
    always_comb
    begin
        last_item  = item_reg[ND-1];
        hit_next   = last_item.hit;
        depth_next = '0;
        nrm_next   = '0;
        pnt_next   = '0;
        qe         = '0;
        if (last_item.hit)
        begin
            pnt_next = last_item.pnt;
            if (last_item.sphere)
            begin
                depth_next = sdep_reg[ND-1];
                for (int i = 0; i < 3; i++)
                begin
                    qe = {2'b00, q_reg[ND-1][i]};
                    nrm_next[i] = last_item.neg[i] ? (16'd0 - qe) : qe;
                end
            end
            else
            begin
                depth_next = last_item.depth;
                nrm_next   = last_item.nrm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v_out_reg <= 1'b0;
            for (int s = 0; s < ND; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            v0_reg       <= in_valid;
            valid_reg[0] <= v0_reg;
            for (int s = 1; s < ND; s++)
                valid_reg[s] <= valid_reg[s-1];
            v_out_reg    <= valid_reg[ND-1];
        end
    end

    always_ff @(posedge clk)
    begin
        item0_reg   <= in_item;
        dist0_reg   <= dist0_next;
        sdepth0_reg <= {1'b0, in_item.rs} - dist0_next;
        item_reg[0] <= item0_reg;
        dist_reg[0] <= dist0_reg;
        sdep_reg[0] <= sdepth0_reg;
        for (int s = 1; s < ND; s++)
        begin
            item_reg[s] <= item_reg[s-1];
            dist_reg[s] <= dist_reg[s-1];
            sdep_reg[s] <= sdep_reg[s-1];
        end
        for (int s = 0; s < ND; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
        end
        hit_reg   <= hit_next;
        depth_reg <= depth_next;
        nrm_reg   <= nrm_next;
        pnt_reg   <= pnt_next;
    end

    assign out_valid = v_out_reg;
    assign out_hit   = hit_reg;
    assign out_depth = depth_reg;
    assign out_nrm   = nrm_reg;
    assign out_pnt   = pnt_reg;

endmodule

[hw/rtl/box_sphere_contact_test_top.sv]
// top level of the box and sphere contact test
// A pair is taken on every clock where start is high; busy never rises. Each pair gives one
// result beat, marked by done for one cycle, in input order. The path runs through three
// front stages, the 31-stage square root and the 14-stage normal division; the receiver
// cannot stall, so results must be taken as they appear.
module box_sphere_contact_test_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               a_is_sphere,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic [30:0]        ext_sum_x,
    input  logic [30:0]        ext_sum_y,
    input  logic [30:0]        ext_sum_z,
    output logic               done,
    output logic               hit,
    output logic signed [31:0] depth,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z
);

    logic                        f_valid;
    bsct_pkg::item_t             f_item;
    logic [bsct_pkg::RAD_W-1:0]  f_rad;
    logic                        s_valid;
    bsct_pkg::item_t             s_item;
    logic [30:0]                 s_root;
    logic [2:0][15:0]            nrm;
    logic [2:0][31:0]            pnt;
    logic [31:0]                 dep;

    assign busy = 1'b0;

    bsct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .sphere    (a_is_sphere),
        .pa        ({a_z, a_y, a_x}),
        .pb        ({b_z, b_y, b_x}),
        .ext       ({ext_sum_z, ext_sum_y, ext_sum_x}),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_rad   (f_rad)
    );

    bsct_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_rad    (f_rad),
        .out_valid (s_valid),
        .out_item  (s_item),
        .out_root  (s_root)
    );

    bsct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .in_root   (s_root),
        .out_valid (done),
        .out_hit   (hit),
        .out_depth (dep),
        .out_nrm   (nrm),
        .out_pnt   (pnt)
    );

    assign depth    = dep;
    assign normal_x = nrm[0];
    assign normal_y = nrm[1];
    assign normal_z = nrm[2];
    assign point_x  = pnt[0];
    assign point_y  = pnt[1];
    assign point_z  = pnt[2];

endmodule
